// ----- rtl/saq_pkg.sv -----
// shared types and constants for the sorted alarm queue
package saq_pkg;

    localparam int DefaultNumAlarms = 16;
    localparam int MaxOut           = 16;
    localparam int OutCntW          = $clog2(MaxOut + 1);
    localparam int OutIdxW          = $clog2(MaxOut);
    localparam int IdW              = 4;
    localparam int TimeW            = 64;
    localparam int CmpW             = 32;
    localparam int PendW            = 5;
    localparam int FuncW            = 2;

    typedef enum logic [FuncW-1:0] {
        FUNC_ARM    = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_INTR   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] dl;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] when;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_FIRE,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/saq_cell.sv -----
// one queue slot: holds an alarm entry and trades it with its neighbors
module saq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  saq_pkg::t_cell_cmd i_cmd,
    input  saq_pkg::t_entry    i_left,
    input  logic               i_left_gt,
    input  saq_pkg::t_entry    i_right,
    input  logic               i_hit,
    output logic               o_hit,
    output logic               o_gt,
    output saq_pkg::t_entry    o_entry
);

    saq_pkg::t_entry r_entry;
    saq_pkg::t_entry n_entry;
    logic            own_hit;

    assign own_hit = r_entry.valid && (r_entry.id == i_cmd.id);
    assign o_hit   = i_hit || own_hit;
    assign o_gt    = r_entry.valid && (r_entry.dl > i_cmd.when);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            saq_pkg::CELL_REMOVE: begin
                if (o_hit) begin
                    n_entry = i_right;
                end
            end
            saq_pkg::CELL_INSERT: begin
                if (i_left_gt) begin
                    n_entry = i_left;
                end else if ((o_gt || !r_entry.valid) && i_left.valid) begin
                    n_entry.valid = 1'b1;
                    n_entry.id    = i_cmd.id;
                    n_entry.dl    = i_cmd.when;
                end
            end
            saq_pkg::CELL_SHIFT: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ----- rtl/sorted_alarm_queue.sv -----
// sorted alarm queue: sequencer, fired-id buffer and a row of queue cells
//
// Command channel: present i_func, i_alarm_id, i_delay and i_now with start
// high while busy is low; the request is taken at that clock edge and busy
// stays high until its last result has gone out.
// Results: each result sits on the o_ ports for one cycle with o_strobe
// high; o_last marks the final result of a request. A request that fires
// nothing gives one status result with o_fired_valid low.
// Sequence by function: arm removes the id, files it again when i_delay is
// nonzero, then runs the fire walk and emits; arm with no delay skips the
// filing step; alarm interrupt runs the fire walk and emits; cancel removes
// the id and emits one status result; an unused func emits one status result.
// The fire walk pops one due alarm off the head of the cell row per cycle.
// Busy returns low after the last result.
// Reset empties the queue, clears the compare and enable holds and returns
// to idle. Results cannot be held off by the receiver.
module sorted_alarm_queue #(
    parameter int NUM_ALARMS = saq_pkg::DefaultNumAlarms
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [saq_pkg::FuncW-1:0]  i_func,
    input  logic [saq_pkg::IdW-1:0]    i_alarm_id,
    input  logic [saq_pkg::TimeW-1:0]  i_delay,
    input  logic [saq_pkg::TimeW-1:0]  i_now,
    output logic                       o_strobe,
    output logic                       o_fired_valid,
    output logic [saq_pkg::IdW-1:0]    o_fired_id,
    output logic [saq_pkg::CmpW-1:0]   o_compare_value,
    output logic                       o_intr_enable,
    output logic [saq_pkg::PendW-1:0]  o_pending_count,
    output logic                       o_last
);

    localparam int CntW = $clog2(NUM_ALARMS + 1);

    saq_pkg::t_state               r_state, n_state;
    saq_pkg::t_func                r_func, n_func;
    logic [saq_pkg::IdW-1:0]       r_id, n_id;
    logic [saq_pkg::TimeW-1:0]     r_when, n_when;
    logic [saq_pkg::TimeW-1:0]     r_now, n_now;
    logic                          r_arm_new, n_arm_new;
    logic [saq_pkg::OutCntW-1:0]   r_n, n_n;
    logic [saq_pkg::OutIdxW-1:0]   r_k, n_k;
    logic [CntW-1:0]               r_count, n_count;
    logic [saq_pkg::CmpW-1:0]      r_cmp, n_cmp;
    logic                          r_en, n_en;
    logic [saq_pkg::IdW-1:0]       r_fired [saq_pkg::MaxOut];
    logic [saq_pkg::IdW-1:0]       fired_rd;
    logic                          fire_we;
    logic                          due;
    logic                          id_ok;
    logic                          is_last;
    logic [CntW+saq_pkg::PendW-1:0] cnt_wide;

    saq_pkg::t_cell_cmd cmd;
    saq_pkg::t_entry    w_entry [NUM_ALARMS];
    saq_pkg::t_entry    w_left  [NUM_ALARMS];
    saq_pkg::t_entry    w_right [NUM_ALARMS];
    logic               w_gt    [NUM_ALARMS];
    logic               w_lgt   [NUM_ALARMS];
    logic               w_hin   [NUM_ALARMS];
    logic               w_hout  [NUM_ALARMS];

    genvar g;
    generate
        for (g = 0; g < NUM_ALARMS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = '{valid: 1'b1, id: '0, dl: '0};
                assign w_lgt[g]  = 1'b0;
                assign w_hin[g]  = 1'b0;
            end else begin : g_body
                assign w_left[g] = w_entry[g-1];
                assign w_lgt[g]  = w_gt[g-1];
                assign w_hin[g]  = w_hout[g-1];
            end
            if (g == NUM_ALARMS - 1) begin : g_tail
                assign w_right[g] = '{valid: 1'b0, id: '0, dl: '0};
            end else begin : g_mid
                assign w_right[g] = w_entry[g+1];
            end
            saq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd),
                .i_left    (w_left[g]),
                .i_left_gt (w_lgt[g]),
                .i_right   (w_right[g]),
                .i_hit     (w_hin[g]),
                .o_hit     (w_hout[g]),
                .o_gt      (w_gt[g]),
                .o_entry   (w_entry[g])
            );
        end
    endgenerate

    assign id_ok   = int'(r_id) < NUM_ALARMS;
    assign due     = w_entry[0].valid && (w_entry[0].dl <= r_now) &&
                     (r_n < saq_pkg::OutCntW'(saq_pkg::MaxOut));
    assign is_last = (r_n == '0) ||
                     ((saq_pkg::OutCntW'(r_k) + saq_pkg::OutCntW'(1)) == r_n);
    assign cnt_wide = (CntW + saq_pkg::PendW)'(r_count);

    assign busy            = (r_state != saq_pkg::ST_IDLE);
    assign o_strobe        = (r_state == saq_pkg::ST_EMIT);
    assign o_fired_valid   = (r_n != '0);
    assign o_fired_id      = (r_n != '0) ? fired_rd : '0;
    assign o_compare_value = r_cmp;
    assign o_intr_enable   = r_en;
    assign o_pending_count = cnt_wide[saq_pkg::PendW-1:0];
    assign o_last          = is_last;

    assign fired_rd = r_fired[r_k];

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_id      = r_id;
        n_when    = r_when;
        n_now     = r_now;
        n_arm_new = r_arm_new;
        n_n       = r_n;
        n_k       = r_k;
        n_count   = r_count;
        n_cmp     = r_cmp;
        n_en      = r_en;
        fire_we   = 1'b0;
        cmd.op    = saq_pkg::CELL_HOLD;
        cmd.id    = r_id;
        cmd.when  = r_when;
        case (r_state)
            saq_pkg::ST_IDLE: begin
                if (start) begin
                    n_func    = saq_pkg::t_func'(i_func);
                    n_id      = i_alarm_id;
                    n_when    = i_now + i_delay;
                    n_now     = i_now;
                    n_arm_new = (i_delay != '0);
                    n_n       = '0;
                    n_k       = '0;
                    case (saq_pkg::t_func'(i_func))
                        saq_pkg::FUNC_ARM,
                        saq_pkg::FUNC_CANCEL: n_state = saq_pkg::ST_REMOVE;
                        saq_pkg::FUNC_INTR:   n_state = saq_pkg::ST_FIRE;
                        default:              n_state = saq_pkg::ST_EMIT;
                    endcase
                end
            end
            saq_pkg::ST_REMOVE: begin
                cmd.op = saq_pkg::CELL_REMOVE;
                if (w_hout[NUM_ALARMS-1]) begin
                    n_count = r_count - CntW'(1);
                end
                if (r_func == saq_pkg::FUNC_ARM) begin
                    n_state = r_arm_new ? saq_pkg::ST_INSERT : saq_pkg::ST_FIRE;
                end else begin
                    n_state = saq_pkg::ST_EMIT;
                end
            end
            saq_pkg::ST_INSERT: begin
                if (id_ok && (r_count < CntW'(NUM_ALARMS))) begin
                    cmd.op  = saq_pkg::CELL_INSERT;
                    n_count = r_count + CntW'(1);
                end
                n_state = saq_pkg::ST_FIRE;
            end
            saq_pkg::ST_FIRE: begin
                if (due) begin
                    cmd.op  = saq_pkg::CELL_SHIFT;
                    fire_we = 1'b1;
                    n_n     = r_n + saq_pkg::OutCntW'(1);
                    n_count = r_count - CntW'(1);
                end else begin
                    if (w_entry[0].valid) begin
                        n_cmp = w_entry[0].dl[saq_pkg::CmpW-1:0];
                        n_en  = 1'b1;
                    end else begin
                        n_en  = 1'b0;
                    end
                    n_state = saq_pkg::ST_EMIT;
                end
            end
            saq_pkg::ST_EMIT: begin
                if (is_last) begin
                    n_state = saq_pkg::ST_IDLE;
                end else begin
                    n_k = r_k + saq_pkg::OutIdxW'(1);
                end
            end
            default: begin
                n_state = saq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= saq_pkg::ST_IDLE;
            r_count <= '0;
            r_cmp   <= '0;
            r_en    <= 1'b0;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_en    <= n_en;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_id      <= n_id;
        r_when    <= n_when;
        r_now     <= n_now;
        r_arm_new <= n_arm_new;
    end

    always_ff @(posedge i_clk) begin
        if (fire_we) begin
            r_fired[r_n[saq_pkg::OutIdxW-1:0]] <= w_entry[0].id;
        end
    end

endmodule

// ----- sim/sorted_alarm_queue_tb.sv -----
// self-checking testbench for the sorted alarm queue: directed and random requests
`timescale 1ns / 1ps

module sorted_alarm_queue_tb;

    localparam int NALARM      = saq_pkg::DefaultNumAlarms;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 125;

    typedef struct {
        saq_pkg::t_func                  op;
        logic [saq_pkg::IdW-1:0]         id;
        logic [saq_pkg::TimeW-1:0]       dly;
        logic [saq_pkg::TimeW-1:0]       tnow;
        int                              gap;
        bit                              drain;
    } t_alarm_req;

    typedef struct {
        logic                            fv;
        logic [saq_pkg::IdW-1:0]         fid;
        logic [saq_pkg::CmpW-1:0]        cmp;
        logic                            ien;
        logic [saq_pkg::PendW-1:0]       cnt;
        logic                            lst;
    } t_alarm_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [saq_pkg::FuncW-1:0]       i_func = '0;
    logic [saq_pkg::IdW-1:0]         i_alarm_id = '0;
    logic [saq_pkg::TimeW-1:0]       i_delay = '0;
    logic [saq_pkg::TimeW-1:0]       i_now = '0;
    logic                            o_strobe;
    logic                            o_fired_valid;
    logic [saq_pkg::IdW-1:0]         o_fired_id;
    logic [saq_pkg::CmpW-1:0]        o_compare_value;
    logic                            o_intr_enable;
    logic [saq_pkg::PendW-1:0]       o_pending_count;
    logic                            o_last;

    // shadow of the alarm queue
    logic [saq_pkg::TimeW-1:0]       alarm_deadline [NALARM];
    bit                              alarm_armed [NALARM];
    logic [saq_pkg::IdW-1:0]         alarm_order [NALARM];
    int                              armed_count;
    logic [saq_pkg::CmpW-1:0]        cmp_reg;
    logic                            ien_reg;
    logic [saq_pkg::IdW-1:0]         due_ids [$];

    t_alarm_req                      pending_requests [$];
    t_alarm_res                      expected_fires [$];
    t_alarm_req                      active_req;
    int                              idle_cycles = 0;
    int                              requests_done = 0;
    int                              total_requests = 0;
    int                              errors = 0;
    int                              cycle_cnt = 0;
    bit                              no_idle = 1'b0;

    sorted_alarm_queue uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_alarm_id      (i_alarm_id),
        .i_delay         (i_delay),
        .i_now           (i_now),
        .o_strobe        (o_strobe),
        .o_fired_valid   (o_fired_valid),
        .o_fired_id      (o_fired_id),
        .o_compare_value (o_compare_value),
        .o_intr_enable   (o_intr_enable),
        .o_pending_count (o_pending_count),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void drop_alarm(logic [saq_pkg::IdW-1:0] id);
        int w;
        w = 0;
        if (!alarm_armed[id]) return;
        for (int i = 0; i < armed_count; i++) begin
            if (alarm_order[i] != id) begin
                alarm_order[w] = alarm_order[i];
                w++;
            end
        end
        armed_count = w;
        alarm_armed[id] = 1'b0;
    endfunction

    function automatic void file_alarm(logic [saq_pkg::IdW-1:0] id,
                                       logic [saq_pkg::TimeW-1:0] when);
        int pos;
        pos = 0;
        if (armed_count >= NALARM) return;
        while (pos < armed_count && alarm_deadline[alarm_order[pos]] <= when) pos++;
        for (int k = armed_count; k > pos; k--) alarm_order[k] = alarm_order[k-1];
        alarm_order[pos] = id;
        alarm_deadline[id] = when;
        alarm_armed[id] = 1'b1;
        armed_count++;
    endfunction

    function automatic void fire_due_alarms(logic [saq_pkg::TimeW-1:0] t);
        int w;
        logic [saq_pkg::IdW-1:0] aid;
        w = 0;
        for (int i = 0; i < armed_count; i++) begin
            aid = alarm_order[i];
            if (alarm_deadline[aid] <= t && due_ids.size() < saq_pkg::MaxOut) begin
                due_ids.push_back(aid);
                alarm_armed[aid] = 1'b0;
            end else begin
                alarm_order[w] = aid;
                w++;
            end
        end
        armed_count = w;
        if (armed_count > 0) begin
            cmp_reg = alarm_deadline[alarm_order[0]][saq_pkg::CmpW-1:0];
            ien_reg = 1'b1;
        end else begin
            ien_reg = 1'b0;
        end
    endfunction

    function automatic void predict_request(t_alarm_req r);
        t_alarm_res res;
        due_ids.delete();
        case (r.op)
            saq_pkg::FUNC_ARM: begin
                drop_alarm(r.id);
                if (r.dly != '0) file_alarm(r.id, r.tnow + r.dly);
                fire_due_alarms(r.tnow);
            end
            saq_pkg::FUNC_CANCEL: drop_alarm(r.id);
            saq_pkg::FUNC_INTR: fire_due_alarms(r.tnow);
            default: ;
        endcase
        res.cmp = cmp_reg;
        res.ien = ien_reg;
        res.cnt = saq_pkg::PendW'(armed_count);
        if (due_ids.size() == 0) begin
            res.fv = 1'b0;
            res.fid = '0;
            res.lst = 1'b1;
            expected_fires.push_back(res);
        end else begin
            foreach (due_ids[k]) begin
                res.fv = 1'b1;
                res.fid = due_ids[k];
                res.lst = (k == due_ids.size() - 1);
                expected_fires.push_back(res);
            end
        end
    endfunction

    function automatic void queue_request(saq_pkg::t_func op, int id,
                                          logic [saq_pkg::TimeW-1:0] dly,
                                          logic [saq_pkg::TimeW-1:0] t, bit drain);
        t_alarm_req r;
        int roll;
        roll = $urandom_range(0, 15);
        r.op = op;
        r.id = saq_pkg::IdW'(id);
        r.dly = dly;
        r.tnow = t;
        r.drain = drain;
        if (no_idle) r.gap = 0;
        else if (roll == 0) r.gap = $urandom_range(8, 40);
        else if (roll < 6) r.gap = 0;
        else r.gap = $urandom_range(1, 3);
        pending_requests.push_back(r);
        total_requests++;
    endfunction

    function automatic logic [saq_pkg::TimeW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void compare_field(string fld, logic [saq_pkg::TimeW-1:0] want,
                                          logic [saq_pkg::TimeW-1:0] got);
        if (want !== got) begin
            $display("%t mismatch on %s: expected %0h actual %0h", $time, fld, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (start && !busy) begin
                predict_request(active_req);
                requests_done++;
            end
            if (!start || !busy) begin
                if (pending_requests.size() > 0 && idle_cycles >= pending_requests[0].gap &&
                    (!pending_requests[0].drain || expected_fires.size() == 0)) begin
                    active_req = pending_requests.pop_front();
                    start <= 1'b1;
                    i_func <= active_req.op;
                    i_alarm_id <= active_req.id;
                    i_delay <= active_req.dly;
                    i_now <= active_req.tnow;
                    idle_cycles <= 0;
                end else begin
                    start <= 1'b0;
                    idle_cycles <= idle_cycles + 1;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_alarm_res e;
        if (i_rst_n && o_strobe) begin
            if (expected_fires.size() == 0) begin
                $display("%t unexpected result: fired_valid %0b fired_id %0h", $time,
                         o_fired_valid, o_fired_id);
                errors++;
            end else begin
                e = expected_fires.pop_front();
                compare_field("fired_valid", e.fv, o_fired_valid);
                compare_field("fired_id", e.fid, o_fired_id);
                compare_field("compare_value", e.cmp, o_compare_value);
                compare_field("intr_enable", e.ien, o_intr_enable);
                compare_field("pending_count", e.cnt, o_pending_count);
                compare_field("last", e.lst, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [saq_pkg::TimeW-1:0] tnow;
        int sel;
        int id;
        bit drain;

        foreach (alarm_armed[i]) alarm_armed[i] = 1'b0;
        armed_count = 0;
        cmp_reg = '0;
        ien_reg = 1'b0;

        // directed part
        queue_request(saq_pkg::FUNC_NONE, 15, '1, '1, 1'b0);
        queue_request(saq_pkg::FUNC_ARM, 0, 64'd1, 64'd0, 1'b0);
        queue_request(saq_pkg::FUNC_ARM, 15, '1, 64'd5, 1'b0);
        for (int i = 0; i < NALARM; i++) begin
            queue_request(saq_pkg::FUNC_ARM, i, 64'd100, 64'd1000, 1'b0);
        end
        queue_request(saq_pkg::FUNC_INTR, 0, 64'd0, 64'd1100, 1'b1);
        queue_request(saq_pkg::FUNC_ARM, 5, 64'd200, 64'd1200, 1'b0);
        queue_request(saq_pkg::FUNC_ARM, 5, 64'd50, 64'd1200, 1'b0);
        queue_request(saq_pkg::FUNC_ARM, 6, 64'd300, 64'd1200, 1'b0);
        queue_request(saq_pkg::FUNC_ARM, 6, 64'd0, 64'd1200, 1'b0);
        queue_request(saq_pkg::FUNC_CANCEL, 5, '1, '1, 1'b0);
        queue_request(saq_pkg::FUNC_CANCEL, 5, 64'd0, 64'd0, 1'b0);

        // random part: mostly a steadily advancing clock with some noise
        tnow = rand64();
        for (int i = 0; i < RAND_ITEMS; i++) begin
            no_idle = (i >= 60 && i < 85);
            sel = $urandom_range(0, 99);
            id = $urandom_range(0, NALARM - 1);
            drain = ($urandom_range(0, 24) == 0);
            tnow += $urandom_range(0, 40);
            if (sel < 40) begin
                queue_request(saq_pkg::FUNC_ARM, id,
                              ($urandom_range(0, 19) == 0) ? 64'd0 : 64'($urandom_range(1, 150)),
                              tnow, drain);
            end else if (sel < 50) begin
                queue_request(saq_pkg::FUNC_CANCEL, id, rand64(), rand64(), drain);
            end else if (sel < 80) begin
                if ($urandom_range(0, 9) == 0) tnow += 200;
                queue_request(saq_pkg::FUNC_INTR, id, rand64(), tnow, drain);
            end else if (sel < 85) begin
                queue_request(saq_pkg::FUNC_NONE, id, rand64(), rand64(), drain);
            end else begin
                queue_request(($urandom_range(0, 1) == 0) ? saq_pkg::FUNC_ARM
                                                          : saq_pkg::FUNC_INTR,
                              id, rand64(), rand64(), drain);
            end
        end
        no_idle = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_done != total_requests) @(posedge i_clk);
        while (expected_fires.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/saq_pkg.sv
rtl/saq_cell.sv
rtl/sorted_alarm_queue.sv
sim/sorted_alarm_queue_tb.sv
